// ===== hw/rtl/sacl_pkg.sv =====
// ----------------------------------------------------------------------------
// sacl_pkg
// Shared constants, register indexes and a saturating-increment helper for the LRU cache tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package sacl_pkg;

    localparam int DEF_MAX_SET_BITS = 6;
    localparam int DEF_MAX_WAYS     = 4;
    localparam int DEF_ADDR_WIDTH   = 64;

    localparam int ADDR_FIELD_W = 64;
    localparam int TAG_W        = 62;
    localparam int STAMP_W      = 64;
    localparam int TOTAL_W      = 32;
    localparam int WAY_OUT_W    = 2;
    localparam int OFFSET_W     = 6;
    localparam int SETB_W       = 3;
    localparam int WAYS_CFG_W   = 3;

    localparam int S_TDATA_W = ADDR_FIELD_W;
    localparam int M_FIELDS_W = 1 + 1 + WAY_OUT_W + 3 * TOTAL_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = OFFSET_W;

    localparam logic [CFG_IDX_W-1:0] CFG_SET_INDEX_BITS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_OFFSET_BITS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE       = 2'd2;

    localparam logic [SETB_W-1:0]     RST_SET_INDEX_BITS    = 3'd4;
    localparam logic [OFFSET_W-1:0]   RST_BLOCK_OFFSET_BITS = 6'd4;
    localparam logic [WAYS_CFG_W-1:0] RST_WAYS_IN_USE       = 3'd1;

    function automatic logic [TOTAL_W-1:0] sat_inc(input logic [TOTAL_W-1:0] v);
        sat_inc = (v == {TOTAL_W{1'b1}}) ? v : v + 1'b1;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/set_assoc_cache_lru_sim.sv =====
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_sim
// Tag-only set-associative cache tracker with LRU replacement.
// ----------------------------------------------------------------------------
// Each address beat is looked up in one set; the block reports hit, eviction,
// the way used and saturating hit/miss/eviction totals, one result beat per
// address beat. From acceptance until its result is loaded into the output
// register and s_tready rises again, an access passes through a state that
// splits the address, a scan that reads each way in use from the single-port
// tag/stamp memory and then drains its read register, a write-back state
// and a load state. The load waits for as long as an earlier result still
// sits unaccepted in the output register. Line valid bits sit in flip-flops
// cleared by reset, so the block is ready right after reset. Configuration
// writes are accepted at any time but are meant for idle periods.
`default_nettype none

module set_assoc_cache_lru_sim #(
    parameter int MAX_SET_BITS = sacl_pkg::DEF_MAX_SET_BITS,
    parameter int MAX_WAYS     = sacl_pkg::DEF_MAX_WAYS,
    parameter int ADDR_WIDTH   = sacl_pkg::DEF_ADDR_WIDTH
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // address
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [sacl_pkg::S_TDATA_W-1:0]   s_tdata,
    // was_hit, was_evicted, way_used[1:0], hits_so_far[31:0],
    // misses_so_far[31:0], evictions_so_far[31:0], zero pad
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [sacl_pkg::M_TDATA_W-1:0]        m_tdata,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [sacl_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [sacl_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import sacl_pkg::*;

    localparam int LINE_COUNT = (1 << MAX_SET_BITS) * MAX_WAYS;
    localparam int IDX_W      = $clog2(LINE_COUNT);
    localparam int WAY_W      = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int CNT_W      = $clog2(MAX_WAYS + 1);
    localparam int SB_W       = $clog2(MAX_SET_BITS + 1);
    localparam int ENTRY_W    = TAG_W + STAMP_W;
    localparam logic [ADDR_FIELD_W-1:0] ADDR_MASK = (ADDR_WIDTH >= ADDR_FIELD_W) ?
        {ADDR_FIELD_W{1'b1}} : ((ADDR_FIELD_W'(1) << ADDR_WIDTH) - 1'b1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SPLIT,
        S_SCAN,
        S_UPDATE,
        S_EMIT
    } state_t;

    state_t state_reg;

    logic [SETB_W-1:0]     set_bits_reg;
    logic [OFFSET_W-1:0]   offset_bits_reg;
    logic [WAYS_CFG_W-1:0] ways_cfg_reg;

    logic [ADDR_FIELD_W-1:0] addr_reg;
    logic [TAG_W-1:0]        tag_reg;
    logic [IDX_W-1:0]        base_reg;
    logic [CNT_W-1:0]        ways_reg;
    logic [CNT_W-1:0]        scan_cnt_reg;

    logic               hit_found_reg;
    logic [WAY_W-1:0]   hit_way_reg;
    logic               free_found_reg;
    logic [WAY_W-1:0]   free_way_reg;
    logic [STAMP_W-1:0] best_stamp_reg;
    logic [WAY_W-1:0]   best_way_reg;

    logic               res_hit_reg;
    logic               res_evict_reg;
    logic [WAY_W-1:0]   res_way_reg;

    logic [STAMP_W-1:0] stamp_clock_reg;
    logic [TOTAL_W-1:0] hit_total_reg;
    logic [TOTAL_W-1:0] miss_total_reg;
    logic [TOTAL_W-1:0] evict_total_reg;

    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    logic                 valid_reg [LINE_COUNT];
    logic [ENTRY_W-1:0]   line_mem  [LINE_COUNT];
    logic [ENTRY_W-1:0]   rd_data_reg;

    // address split
    logic [31:0]             sb_wide;
    logic [31:0]             ways_wide;
    logic [SB_W-1:0]         sb_eff;
    logic [OFFSET_W-1:0]     bb_eff;
    logic [CNT_W-1:0]        ways_eff;
    logic [ADDR_FIELD_W-1:0] addr_sh;
    logic [ADDR_FIELD_W-1:0] tag_sh;
    logic [MAX_SET_BITS-1:0] set_val;

    always_comb begin
        sb_wide = 32'(set_bits_reg);
        if (sb_wide == 32'd0) begin
            sb_wide = 32'd1;
        end else if (sb_wide > 32'(MAX_SET_BITS)) begin
            sb_wide = 32'(MAX_SET_BITS);
        end
        ways_wide = 32'(ways_cfg_reg);
        if (ways_wide == 32'd0) begin
            ways_wide = 32'd1;
        end else if (ways_wide > 32'(MAX_WAYS)) begin
            ways_wide = 32'(MAX_WAYS);
        end
        sb_eff   = SB_W'(sb_wide);
        ways_eff = CNT_W'(ways_wide);
        bb_eff   = (offset_bits_reg == '0) ? OFFSET_W'(1) : offset_bits_reg;
        addr_sh  = addr_reg >> bb_eff;
        tag_sh   = addr_sh >> sb_eff;
        set_val  = addr_sh[MAX_SET_BITS-1:0] & ~({MAX_SET_BITS{1'b1}} << sb_eff);
    end

    // way scan
    logic [WAY_W-1:0]   issue_way;
    logic [IDX_W-1:0]   issue_idx;
    logic               rd_en;
    logic [WAY_W-1:0]   eval_way;
    logic [IDX_W-1:0]   eval_idx;
    logic               eval_en;
    logic               eval_valid;
    logic [TAG_W-1:0]   rd_tag;
    logic [STAMP_W-1:0] rd_stamp;

    assign issue_way  = WAY_W'(scan_cnt_reg);
    assign issue_idx  = base_reg + IDX_W'(issue_way);
    assign rd_en      = (state_reg == S_SCAN) && (scan_cnt_reg < ways_reg);
    assign eval_way   = WAY_W'(scan_cnt_reg - 1'b1);
    assign eval_idx   = base_reg + IDX_W'(eval_way);
    assign eval_en    = (state_reg == S_SCAN) && (scan_cnt_reg != '0);
    assign eval_valid = valid_reg[eval_idx];
    assign rd_tag     = rd_data_reg[ENTRY_W-1:STAMP_W];
    assign rd_stamp   = rd_data_reg[STAMP_W-1:0];

    // write-back
    logic [WAY_W-1:0]   upd_way;
    logic               upd_evict;
    logic [IDX_W-1:0]   upd_idx;
    logic [STAMP_W-1:0] stamp_next;
    logic               wr_en;

    assign upd_way    = hit_found_reg ? hit_way_reg :
                        (free_found_reg ? free_way_reg : best_way_reg);
    assign upd_evict  = !hit_found_reg && !free_found_reg;
    assign upd_idx    = base_reg + IDX_W'(upd_way);
    assign stamp_next = stamp_clock_reg + 1'b1;
    assign wr_en      = (state_reg == S_UPDATE);

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            set_bits_reg    <= RST_SET_INDEX_BITS;
            offset_bits_reg <= RST_BLOCK_OFFSET_BITS;
            ways_cfg_reg    <= RST_WAYS_IN_USE;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_SET_INDEX_BITS:    set_bits_reg    <= cfg_data[SETB_W-1:0];
                CFG_BLOCK_OFFSET_BITS: offset_bits_reg <= cfg_data;
                CFG_WAYS_IN_USE:       ways_cfg_reg    <= cfg_data[WAYS_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < LINE_COUNT; i++) begin
                valid_reg[i] <= 1'b0;
            end
        end else if (wr_en) begin
            valid_reg[upd_idx] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            line_mem[upd_idx] <= {tag_reg, stamp_next};
        end
        if (rd_en) begin
            rd_data_reg <= line_mem[issue_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            m_tvalid_reg    <= 1'b0;
            stamp_clock_reg <= STAMP_W'(1);
            hit_total_reg   <= '0;
            miss_total_reg  <= '0;
            evict_total_reg <= '0;
        end else begin
            if (m_tvalid_reg && m_tready && state_reg != S_EMIT) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        addr_reg  <= s_tdata & ADDR_MASK;
                        state_reg <= S_SPLIT;
                    end
                end
                S_SPLIT: begin
                    tag_reg        <= tag_sh[TAG_W-1:0];
                    base_reg       <= IDX_W'(IDX_W'(set_val) * IDX_W'(MAX_WAYS));
                    ways_reg       <= ways_eff;
                    scan_cnt_reg   <= '0;
                    hit_found_reg  <= 1'b0;
                    free_found_reg <= 1'b0;
                    state_reg      <= S_SCAN;
                end
                S_SCAN: begin
                    if (eval_en) begin
                        if (!hit_found_reg && eval_valid && rd_tag == tag_reg) begin
                            hit_found_reg <= 1'b1;
                            hit_way_reg   <= eval_way;
                        end
                        if (!free_found_reg && !eval_valid) begin
                            free_found_reg <= 1'b1;
                            free_way_reg   <= eval_way;
                        end
                        if (eval_way == '0 || rd_stamp < best_stamp_reg) begin
                            best_stamp_reg <= rd_stamp;
                            best_way_reg   <= eval_way;
                        end
                    end
                    if (scan_cnt_reg == ways_reg) begin
                        state_reg <= S_UPDATE;
                    end else begin
                        scan_cnt_reg <= scan_cnt_reg + 1'b1;
                    end
                end
                S_UPDATE: begin
                    stamp_clock_reg <= stamp_next;
                    res_hit_reg     <= hit_found_reg;
                    res_evict_reg   <= upd_evict;
                    res_way_reg     <= upd_way;
                    if (hit_found_reg) begin
                        hit_total_reg <= sat_inc(hit_total_reg);
                    end else begin
                        miss_total_reg <= sat_inc(miss_total_reg);
                    end
                    if (upd_evict) begin
                        evict_total_reg <= sat_inc(evict_total_reg);
                    end
                    state_reg <= S_EMIT;
                end
                S_EMIT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= M_TDATA_W'({evict_total_reg, miss_total_reg,
                                                    hit_total_reg,
                                                    WAY_OUT_W'(res_way_reg),
                                                    res_evict_reg, res_hit_reg});
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_hit_no_evict: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_UPDATE) |=> !(res_hit_reg && res_evict_reg))
        else $error("hit and eviction flagged together");

    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN) |-> (scan_cnt_reg <= ways_reg))
        else $error("way scan ran past ways in use");

    a_evict_le_miss: assert property (@(posedge aclk) disable iff (!aresetn)
        evict_total_reg <= miss_total_reg)
        else $error("eviction total exceeds miss total");

    a_stamp_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_UPDATE) |=> $stable(stamp_clock_reg))
        else $error("stamp clock moved outside write-back");

    a_out_from_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == S_EMIT))
        else $error("result beat raised outside emit");

endmodule

`default_nettype wire

// ===== bench/set_assoc_cache_lru_sim_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_sim_tb
// Self-checking bench for the tag-only LRU cache tracker. A short directed
// table covers reset behavior, eviction, field extremes and out-of-range
// settings. It is followed by random access phases under changing set,
// offset and way settings. Every result beat is checked against a local
// model of the tags, stamps and totals, or against the table's own values.
// ----------------------------------------------------------------------------
module set_assoc_cache_lru_sim_tb;
    import sacl_pkg::*;

    localparam int LINES         = (1 << DEF_MAX_SET_BITS) * DEF_MAX_WAYS;
    localparam int SETTLE_CYCLES = DEF_MAX_WAYS + 8;
    localparam int DRAIN_GUARD   = 20000;
    localparam int PHASES        = 10;
    localparam int PHASE_ITEMS   = 195;
    localparam int HOLD_CYCLES   = 80;
    localparam int MAX_REPORTS   = 10;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef struct packed {
        logic                 hit;
        logic                 evict;
        logic [WAY_OUT_W-1:0] way;
        logic [TOTAL_W-1:0]   hits;
        logic [TOTAL_W-1:0]   misses;
        logic [TOTAL_W-1:0]   evicts;
    } lookup_t;

    typedef enum logic {ROW_ACCESS, ROW_CONFIG} row_kind_t;
    typedef enum int {RX_OPEN, RX_HALF, RX_SPARSE, RX_TOGGLE} rx_mode_t;

    typedef struct {
        row_kind_t               kind;
        logic [CFG_IDX_W-1:0]    idx;
        logic [CFG_DATA_W-1:0]   val;
        logic [ADDR_FIELD_W-1:0] addr;
        bit                      typed;
        lookup_t                 want;
    } row_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;   // address
    logic                  m_tvalid;
    logic                  m_tready;
    // was_hit, was_evicted, way_used[1:0], hits_so_far[31:0],
    // misses_so_far[31:0], evictions_so_far[31:0], zero pad
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // cache model state
    logic                  valid_mem [LINES];
    logic [TAG_W-1:0]      tag_mem   [LINES];
    logic [STAMP_W-1:0]    stamp_mem [LINES];
    logic [STAMP_W-1:0]    use_clock;
    logic [TOTAL_W-1:0]    hit_cnt;
    logic [TOTAL_W-1:0]    miss_cnt;
    logic [TOTAL_W-1:0]    evict_cnt;
    logic [SETB_W-1:0]     reg_sets;
    logic [OFFSET_W-1:0]   reg_offset;
    logic [WAYS_CFG_W-1:0] reg_ways;

    lookup_t expected_q [$];
    row_t    stim_table [$];
    int      errors;
    int      burst_left;
    bit      rx_hold_req;

    set_assoc_cache_lru_sim u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial aclk = 1'b0;
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic int eff_sets();
        if (reg_sets == 0) return 1;
        if (reg_sets > DEF_MAX_SET_BITS) return DEF_MAX_SET_BITS;
        return int'(reg_sets);
    endfunction

    function automatic int eff_offset();
        if (reg_offset == 0) return 1;
        return int'(reg_offset);
    endfunction

    function automatic int eff_ways();
        if (reg_ways == 0) return 1;
        if (reg_ways > DEF_MAX_WAYS) return DEF_MAX_WAYS;
        return int'(reg_ways);
    endfunction

    function automatic lookup_t cache_lookup(input logic [ADDR_FIELD_W-1:0] addr);
        int                      sb;
        int                      bb;
        int                      nw;
        int                      base;
        int                      victim;
        bit                      placed;
        logic [ADDR_FIELD_W-1:0] set_no;
        logic [ADDR_FIELD_W-1:0] wide;
        logic [TAG_W-1:0]        tag;
        logic [STAMP_W-1:0]      oldest;
        lookup_t                 r;
        sb     = eff_sets();
        bb     = eff_offset();
        nw     = eff_ways();
        set_no = (addr >> bb) & ((64'd1 << sb) - 64'd1);
        wide   = addr >> (bb + sb);
        tag    = wide[TAG_W-1:0];
        base   = int'(set_no) * DEF_MAX_WAYS;
        r      = '0;
        victim = 0;
        placed = 1'b0;
        for (int w = 0; w < nw; w++) begin
            if (!r.hit && valid_mem[base + w] && tag_mem[base + w] == tag) begin
                r.hit  = 1'b1;
                victim = w;
            end
        end
        if (r.hit) begin
            if (~&hit_cnt) hit_cnt = hit_cnt + 1'b1;
        end else begin
            for (int w = 0; w < nw; w++) begin
                if (!placed && !valid_mem[base + w]) begin
                    placed = 1'b1;
                    victim = w;
                end
            end
            if (!placed) begin
                // least recently used, lowest way on ties
                oldest = stamp_mem[base];
                victim = 0;
                for (int w = 1; w < nw; w++) begin
                    if (stamp_mem[base + w] < oldest) begin
                        oldest = stamp_mem[base + w];
                        victim = w;
                    end
                end
                r.evict = 1'b1;
                if (~&evict_cnt) evict_cnt = evict_cnt + 1'b1;
            end
            if (~&miss_cnt) miss_cnt = miss_cnt + 1'b1;
            valid_mem[base + victim] = 1'b1;
            tag_mem[base + victim]   = tag;
        end
        use_clock = use_clock + 1'b1;
        stamp_mem[base + victim] = use_clock;
        r.way    = victim[WAY_OUT_W-1:0];
        r.hits   = hit_cnt;
        r.misses = miss_cnt;
        r.evicts = evict_cnt;
        return r;
    endfunction

    function automatic void add_access(input logic [ADDR_FIELD_W-1:0] addr,
                                       input bit typed = 1'b0,
                                       input lookup_t want = '0);
        row_t row;
        row.kind  = ROW_ACCESS;
        row.idx   = CFG_SET_INDEX_BITS;
        row.val   = '0;
        row.addr  = addr;
        row.typed = typed;
        row.want  = want;
        stim_table.push_back(row);
    endfunction

    function automatic void add_config(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [CFG_DATA_W-1:0] val);
        row_t row;
        row.kind  = ROW_CONFIG;
        row.idx   = idx;
        row.val   = val;
        row.addr  = '0;
        row.typed = 1'b0;
        row.want  = '0;
        stim_table.push_back(row);
    endfunction

    task automatic send_addr(input logic [ADDR_FIELD_W-1:0] addr,
                             input bit typed,
                             input lookup_t want);
        lookup_t got;
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= addr;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        got = cache_lookup(addr);
        expected_q.push_back(typed ? want : got);
    endtask

    task automatic go_idle();
        int guard;
        s_tvalid <= 1'b0;
        burst_left = 0;
        guard = 0;
        while (expected_q.size() != 0 && guard < DRAIN_GUARD) begin
            @(posedge aclk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        go_idle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_SET_INDEX_BITS:    reg_sets   = val[SETB_W-1:0];
            CFG_BLOCK_OFFSET_BITS: reg_offset = val;
            CFG_WAYS_IN_USE:       reg_ways   = val[WAYS_CFG_W-1:0];
            default: ;
        endcase
    endtask

    // result side: ready pattern in runs, plus a long hold-off on request
    initial begin : rx_side
        int       left;
        rx_mode_t mode;
        m_tready = 1'b0;
        left     = 0;
        mode     = RX_OPEN;
        forever begin
            @(posedge aclk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            if (left == 0) begin
                mode = rx_mode_t'($urandom_range(0, 3));
                left = $urandom_range(8, 60);
            end
            left--;
            case (mode)
                RX_OPEN:   m_tready <= 1'b1;
                RX_HALF:   m_tready <= ($urandom_range(0, 1) == 1);
                RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
                default:   m_tready <= ~m_tready;
            endcase
        end
    end

    always @(posedge aclk) begin : check_results
        lookup_t want;
        lookup_t seen;
        if (aresetn && m_tvalid && m_tready) begin
            seen.hit    = m_tdata[0];
            seen.evict  = m_tdata[1];
            seen.way    = m_tdata[3:2];
            seen.hits   = m_tdata[35:4];
            seen.misses = m_tdata[67:36];
            seen.evicts = m_tdata[99:68];
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: result beat with nothing pending: hit=%0d evict=%0d way=%0d",
                             $realtime, seen.hit, seen.evict, seen.way);
            end else begin
                want = expected_q.pop_front();
                if (seen !== want) begin
                    errors++;
                    if (errors <= MAX_REPORTS) begin
                        $display("%0t: mismatch exp hit=%0d evict=%0d way=%0d h=%0d m=%0d e=%0d",
                                 $realtime, want.hit, want.evict, want.way,
                                 want.hits, want.misses, want.evicts);
                        $display("%0t:          got hit=%0d evict=%0d way=%0d h=%0d m=%0d e=%0d",
                                 $realtime, seen.hit, seen.evict, seen.way,
                                 seen.hits, seen.misses, seen.evicts);
                    end
                end
            end
        end
    end

    initial begin : stimulus
        int                      sb;
        int                      bb;
        int                      rs;
        int                      rb;
        int                      rw;
        logic [ADDR_FIELD_W-1:0] addr;
        logic [ADDR_FIELD_W-1:0] tag;
        logic [ADDR_FIELD_W-1:0] set_no;
        logic [ADDR_FIELD_W-1:0] offs;
        logic [ADDR_FIELD_W-1:0] base_set;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        cfg_valid   = 1'b0;
        cfg_index   = CFG_SET_INDEX_BITS;
        cfg_data    = '0;
        aresetn     = 1'b0;
        rx_hold_req = 1'b0;
        errors      = 0;
        burst_left  = 0;
        for (int i = 0; i < LINES; i++) begin
            valid_mem[i] = 1'b0;
            tag_mem[i]   = '0;
            stamp_mem[i] = '0;
        end
        use_clock  = 64'd1;
        hit_cnt    = '0;
        miss_cnt   = '0;
        evict_cnt  = '0;
        reg_sets   = RST_SET_INDEX_BITS;
        reg_offset = RST_BLOCK_OFFSET_BITS;
        reg_ways   = RST_WAYS_IN_USE;

        // reset settings: 16 sets, 16-byte lines, direct mapped
        add_access(64'h0, 1'b1, '{1'b0, 1'b0, 2'd0, 32'd0, 32'd1, 32'd0});
        add_access(64'h0, 1'b1, '{1'b1, 1'b0, 2'd0, 32'd1, 32'd1, 32'd0});
        add_access(64'h100, 1'b1, '{1'b0, 1'b1, 2'd0, 32'd1, 32'd2, 32'd1});
        add_access('1, 1'b1, '{1'b0, 1'b0, 2'd0, 32'd1, 32'd3, 32'd1});
        add_access('1, 1'b1, '{1'b1, 1'b0, 2'd0, 32'd2, 32'd3, 32'd1});
        // four ways: fill set 0, then replace the oldest
        add_config(CFG_WAYS_IN_USE, 6'd4);
        add_access(64'h100);
        add_access(64'h200);
        add_access(64'h300);
        add_access(64'h400);
        add_access(64'h500);
        add_access(64'h100);
        // out-of-range settings are clamped
        add_config(CFG_WAYS_IN_USE, 6'd0);
        add_access(64'h200);
        add_config(CFG_WAYS_IN_USE, 6'h3F);
        add_config(CFG_SET_INDEX_BITS, 6'd0);
        add_config(CFG_BLOCK_OFFSET_BITS, 6'd0);
        add_access(64'h5);
        add_access(64'h7);
        add_config(CFG_SET_INDEX_BITS, 6'd7);
        add_config(CFG_BLOCK_OFFSET_BITS, 6'h3F);
        add_access(64'h8000_0000_0000_0000);
        add_access(64'h0);
        // set field runs past the top of the address
        add_config(CFG_BLOCK_OFFSET_BITS, 6'd60);
        add_access(64'hF000_0000_0000_0000);
        add_config(CFG_SPARE, 6'h2A);
        add_access(64'hAAAA_5555_AAAA_5555);
        add_config(CFG_BLOCK_OFFSET_BITS, 6'd32);
        add_access(64'h5555_AAAA_5555_AAAA);

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (stim_table[i]) begin
            if (stim_table[i].kind == ROW_CONFIG)
                write_cfg(stim_table[i].idx, stim_table[i].val);
            else
                send_addr(stim_table[i].addr, stim_table[i].typed, stim_table[i].want);
        end

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin rs = 6; rb = 1;  rw = 4; end
                1: begin rs = 6; rb = 58; rw = 7; end
                2: begin rs = 1; rb = 63; rw = 2; end
                default: begin
                    rs = $urandom_range(0, 63);
                    rw = $urandom_range(0, 63);
                    if ($urandom_range(0, 3) == 0) begin
                        case ($urandom_range(0, 3))
                            0: rb = 0;
                            1: rb = 32;
                            2: rb = 50;
                            default: rb = 63;
                        endcase
                    end else begin
                        rb = $urandom_range(0, 12);
                    end
                end
            endcase
            write_cfg(CFG_SET_INDEX_BITS, rs[CFG_DATA_W-1:0]);
            write_cfg(CFG_BLOCK_OFFSET_BITS, rb[CFG_DATA_W-1:0]);
            write_cfg(CFG_WAYS_IN_USE, rw[CFG_DATA_W-1:0]);
            if (p == 3 || p == 7) rx_hold_req = 1'b1;
            sb = eff_sets();
            bb = eff_offset();
            base_set = {$urandom, $urandom};
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if ($urandom_range(0, 99) < 12) begin
                    addr = {$urandom, $urandom};
                end else begin
                    // few tags over a few neighboring sets: hits and evictions
                    if ($urandom_range(0, 9) == 0)
                        tag = {$urandom, $urandom};
                    else
                        tag = ADDR_FIELD_W'($urandom_range(0, 5));
                    set_no = (base_set + $urandom_range(0, 2)) & ((64'd1 << sb) - 64'd1);
                    offs   = {$urandom, $urandom} & ((64'd1 << bb) - 64'd1);
                    addr   = (tag << (bb + sb)) | (set_no << bb) | offs;
                end
                send_addr(addr, 1'b0, '0);
            end
        end

        go_idle();
        if (errors == 0 && expected_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin : watchdog
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== set_assoc_cache_lru_sim.f =====
hw/rtl/sacl_pkg.sv
hw/rtl/set_assoc_cache_lru_sim.sv
bench/set_assoc_cache_lru_sim_tb.sv
